// ===== rtl/core/u8ld_pkg.sv =====
package u8ld_pkg;

    localparam int unsigned CpW = 21;

    localparam logic [7:0] RawContTag = 8'h80;

    // one job per accepted word that yields results: optional flush of an
    // open sequence (lead, then held continuations), then an optional final
    typedef struct packed {
        logic            flush;
        logic [7:0]      lead;
        logic [1:0]      held;
        logic [5:0]      pay0;
        logic [5:0]      pay1;
        logic            fin_valid;
        logic [CpW-1:0]  fin_cp;
        logic            fin_raw;
        logic            fin_eos;
    } t_job;

endpackage

// ===== rtl/core/u8ld_front.sv =====
module u8ld_front
    import u8ld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_need, n_need;
    logic [1:0] r_held, n_held;
    logic [5:0] r_pay [2];

    logic       accept;
    logic       in_seq;
    logic       is_cont;
    logic       store;
    t_job       job;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign in_seq  = (r_need != 2'd0);
    assign is_cont = (i_byte_in[7:6] == 2'b10);

    always_comb begin
        job           = '0;
        job.lead      = r_lead;
        job.held      = r_held;
        job.pay0      = r_pay[0];
        job.pay1      = r_pay[1];
        n_lead        = r_lead;
        n_need        = r_need;
        n_held        = r_held;
        store         = 1'b0;
        if (in_seq && is_cont) begin
            if (({1'b0, r_held} + 3'd1) >= {1'b0, r_need}) begin
                job.fin_valid = 1'b1;
                case (r_need)
                    2'd1: job.fin_cp = {10'd0, r_lead[4:0], i_byte_in[5:0]};
                    2'd2: job.fin_cp = {5'd0, r_lead[3:0], r_pay[0], i_byte_in[5:0]};
                    2'd3: job.fin_cp = {r_lead[2:0], r_pay[0], r_pay[1], i_byte_in[5:0]};
                    default: job.fin_cp = '0;
                endcase
                n_lead = '0;
                n_need = '0;
                n_held = '0;
            end else begin
                store  = 1'b1;
                n_held = r_held + 2'd1;
            end
        end else begin
            job.flush = in_seq;
            if (in_seq) begin
                n_lead = '0;
                n_need = '0;
                n_held = '0;
            end
            if (i_byte_in == 8'h00) begin
                job.fin_valid = 1'b1;
                job.fin_eos   = 1'b1;
            end else if (i_byte_in[7] == 1'b0) begin
                job.fin_valid = 1'b1;
                job.fin_cp    = {13'd0, i_byte_in};
            end else if (i_byte_in[7:5] == 3'b110) begin
                n_lead = i_byte_in;
                n_need = 2'd1;
                n_held = '0;
            end else if (i_byte_in[7:4] == 4'b1110) begin
                n_lead = i_byte_in;
                n_need = 2'd2;
                n_held = '0;
            end else if (i_byte_in[7:3] == 5'b11110) begin
                n_lead = i_byte_in;
                n_need = 2'd3;
                n_held = '0;
            end else begin
                job.fin_valid = 1'b1;
                job.fin_raw   = 1'b1;
                job.fin_cp    = {13'd0, i_byte_in};
            end
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.flush || job.fin_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_need <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_need <= n_need;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_pay[r_held[0]] <= i_byte_in[5:0];
        end
    end

endmodule

// ===== rtl/core/u8ld_queue.sv =====
module u8ld_queue
    import u8ld_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nonempty,
    output t_job  o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] Depth   = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full     = (r_cnt == Depth);
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastIdx) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastIdx) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/core/u8ld_back.sv =====
module u8ld_back
    import u8ld_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_nonempty,
    input  t_job            i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CpW-1:0]  o_codepoint,
    output logic            o_raw_fallback,
    output logic            o_end_of_string,
    output logic            o_last_of_run
);

    logic [1:0]     r_step;
    logic           r_valid;
    logic [CpW-1:0] r_cp;
    logic           r_raw, r_eos, r_last;

    logic           load;
    logic [2:0]     total;
    logic           last;
    logic [CpW-1:0] cp;
    logic           raw, eos;
    logic [5:0]     pay;

    assign load  = i_nonempty && (!r_valid || !i_stall);
    assign total = (i_head.flush ? ({1'b0, i_head.held} + 3'd1) : 3'd0)
                 + {2'd0, i_head.fin_valid};
    assign last  = (({1'b0, r_step} + 3'd1) == total);
    assign pay   = r_step[1] ? i_head.pay1 : i_head.pay0;
    assign o_pop = load && last;

    always_comb begin
        cp  = i_head.fin_cp;
        raw = i_head.fin_raw;
        eos = i_head.fin_eos;
        if (i_head.flush && r_step == 2'd0) begin
            cp  = {13'd0, i_head.lead};
            raw = 1'b1;
            eos = 1'b0;
        end else if (i_head.flush && r_step <= i_head.held) begin
            cp  = {13'd0, RawContTag | {2'b00, pay}};
            raw = 1'b1;
            eos = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_step  <= last ? 2'd0 : r_step + 2'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= cp;
            r_raw  <= raw;
            r_eos  <= eos;
            r_last <= last;
        end
    end

    assign o_valid         = r_valid;
    assign o_codepoint     = r_cp;
    assign o_raw_fallback  = r_raw;
    assign o_end_of_string = r_eos;
    assign o_last_of_run   = r_last;

endmodule

// ===== rtl/core/utf8_lenient_decoder_top.sv =====
// Lenient UTF-8 decoder: one byte word in, zero to four codepoint words out.
// Input channel i_valid/o_stall carries i_byte_in; a zero byte ends a string.
// Output channel o_valid/i_stall carries codepoint, raw_fallback,
// end_of_string and last_of_run (set on the final word caused by a byte).
// Lead bytes open a sequence and give no word; a broken sequence is flushed
// as raw bytes before the offending byte is handled afresh.
// A completing byte's job is written to the byte job queue, and its word is
// then loaded into the output register and offered. Throughput: one byte per
// cycle while each byte gives at most one word and the receiver does not
// stall. A byte that gives k words (k up to four on a flush) holds the output
// sequencer until the output register drains all k, one word per cycle while
// unstalled; a queue of DEPTH byte jobs sits between the byte classifier and
// the output sequencer and absorbs that. o_stall rises only when that queue
// is full. Receiver stall holds the output word and lets the queue fill.
// Reset (synchronous, active low) closes any open sequence and empties the
// queue and output register; held continuation payloads are not cleared.
module utf8_lenient_decoder_top
    import u8ld_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_byte_in,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CpW-1:0]  o_codepoint,
    output logic            o_raw_fallback,
    output logic            o_end_of_string,
    output logic            o_last_of_run
);

    logic push, full, pop, nonempty;
    t_job job, head;

    u8ld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_byte_in (i_byte_in),
        .i_full    (full),
        .o_push    (push),
        .o_job     (job)
    );

    u8ld_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    u8ld_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (nonempty),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_codepoint     (o_codepoint),
        .o_raw_fallback  (o_raw_fallback),
        .o_end_of_string (o_end_of_string),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ===== rtl/core/u8ld_checker.sv =====
module u8ld_checker
    import u8ld_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_stall,
    input  logic [7:0]      i_byte_in,
    input  logic            o_valid,
    input  logic            i_stall,
    input  logic [CpW-1:0]  o_codepoint,
    input  logic            o_raw_fallback,
    input  logic            o_end_of_string,
    input  logic            o_last_of_run
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_byte_in))
        else $error("stalled input word changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_codepoint)
            && $stable(o_last_of_run))
        else $error("stalled output word changed");

    a_eos_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_string |->
            o_codepoint == '0 && !o_raw_fallback && o_last_of_run)
        else $error("end word malformed");

    a_raw_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_raw_fallback |-> o_codepoint[CpW-1:8] == '0
            && !o_end_of_string)
        else $error("raw word wider than a byte");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind utf8_lenient_decoder_top u8ld_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_byte_in       (i_byte_in),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_codepoint     (o_codepoint),
    .o_raw_fallback  (o_raw_fallback),
    .o_end_of_string (o_end_of_string),
    .o_last_of_run   (o_last_of_run)
);
